/* rtl/das_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package das_pkg;

    localparam int MAX_ARRAYS = 16;
    localparam int HEAP_WORDS = 4096;
    localparam int NAME_CHARS = 8;

    localparam int KEY_W    = 8 * NAME_CHARS;
    localparam int ENTRY_W  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int COUNT_W  = $clog2(MAX_ARRAYS + 1);
    localparam int HEAP_AW  = $clog2(HEAP_WORDS);
    localparam int FILL_W   = $clog2(HEAP_WORDS + 1);

    localparam int FIELD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int PROD_W   = 2 * SIZE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int WORD_W   = 64;
    localparam int LIMIT_W  = 13;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam int LIMIT_RESET = 4096;

    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_DIM   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_NO_MEMORY  = 3'd2,
        ST_NOT_DIM    = 3'd3,
        ST_BAD_SUB    = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    lookup;
        logic    take_entry;
        logic    mul;
        logic    dim_commit;
        logic    dim_fail;
        logic    clear_wr;
        logic    fetch;
        logic    addr_calc;
        logic    mem_wr;
        logic    rd_capture;
        logic    set_status;
        status_t code;
        logic    load_out;
    } das_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t op;
        logic full;
        logic oom;
        logic bad_name;
        logic bad_sub;
        logic clear_last;
        logic out_free;
    } das_flags_t;

endpackage

`default_nettype wire

/* rtl/das_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module das_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/das_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module das_ctrl
    import das_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire das_flags_t flags,
    output das_cmd_t        cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_LOOKUP    = 11'b00000000010,
        S_DIM_TAKE  = 11'b00000000100,
        S_DIM_CHECK = 11'b00000001000,
        S_CLEAR     = 11'b00000010000,
        S_FETCH     = 11'b00000100000,
        S_CHECK     = 11'b00001000000,
        S_ADDR      = 11'b00010000000,
        S_ACCESS    = 11'b00100000000,
        S_RDWAIT    = 11'b01000000000,
        S_RESP      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                case (flags.op)
                    CMD_DIM:   state_next = S_DIM_TAKE;
                    CMD_READ:  state_next = S_FETCH;
                    CMD_WRITE: state_next = S_FETCH;
                    default: begin
                        // unknown command: answer ok with a zero word
                        cmd.set_status = 1'b1;
                        state_next     = S_RESP;
                    end
                endcase
            end
            S_DIM_TAKE: begin
                if (flags.full) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_TABLE_FULL;
                    state_next     = S_RESP;
                end else begin
                    cmd.take_entry = 1'b1;
                    cmd.mul        = 1'b1;
                    state_next     = S_DIM_CHECK;
                end
            end
            S_DIM_CHECK: begin
                if (flags.oom) begin
                    cmd.dim_fail   = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_NO_MEMORY;
                    state_next     = S_RESP;
                end else begin
                    cmd.dim_commit = 1'b1;
                    state_next     = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (flags.clear_last) begin
                    cmd.set_status = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (flags.bad_name) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_NOT_DIM;
                    state_next     = S_RESP;
                end else if (flags.bad_sub) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_BAD_SUB;
                    state_next     = S_RESP;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                cmd.addr_calc = 1'b1;
                state_next    = S_ACCESS;
            end
            S_ACCESS: begin
                if (flags.op == CMD_WRITE) begin
                    cmd.mem_wr     = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = S_RESP;
                end else begin
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                cmd.rd_capture = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free
                if (flags.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/das_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module das_dpath
    import das_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [CMD_W-1:0]    s_tuser,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                cfg_valid,
    input  wire logic [LIMIT_W-1:0]  cfg_data,
    input  wire das_cmd_t            cmd,
    output das_flags_t               flags,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [M_DATA_W-1:0]      m_tdata
);

    // captured word
    cmd_t                      op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [FIELD_W-1:0] sf_reg, ss_reg, if_reg, is_reg;
    logic [WORD_W-1:0]         wval_reg;

    // descriptor table
    logic [KEY_W-1:0]      keys_reg  [MAX_ARRAYS];
    logic [SIZE_W-1:0]     rows_reg  [MAX_ARRAYS];
    logic [SIZE_W-1:0]     cols_reg  [MAX_ARRAYS];
    logic [HEAP_AW-1:0]    start_reg [MAX_ARRAYS];
    logic [MAX_ARRAYS-1:0] dim_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic               hit_reg, full_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic [SIZE_W-1:0]  ent_rows_reg, ent_cols_reg;
    logic [HEAP_AW-1:0] ent_start_reg;
    logic               ent_dim_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [HEAP_AW-1:0] addr_reg;
    logic [FILL_W-1:0]  ptr_reg, end_reg;
    logic [WORD_W-1:0]  value_reg;
    status_t            status_reg;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [MAX_ARRAYS-1:0] match;
    logic                  hit;
    logic [ENTRY_W-1:0]    hit_idx;
    logic [SIZE_W-1:0]     s1c, s2c, mul_a, mul_b;
    logic [PROD_W-1:0]     words;
    logic [SUM_W-1:0]      eff_limit, need_sum, off_sum, addr_sum;
    logic [FILL_W-1:0]     ptr_inc;
    logic                  ram_we;
    logic [HEAP_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata;

    // name match, lowest live entry first
    always_comb begin
        match   = '0;
        hit_idx = '0;
        for (int i = 0; i < MAX_ARRAYS; i++) begin
            match[i] = (COUNT_W'(i) < count_reg) && (keys_reg[i] == key_reg);
        end
        for (int i = MAX_ARRAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = ENTRY_W'(i);
            end
        end
    end
    assign hit = |match;

    assign s1c = (sf_reg < 16'sd1) ? SIZE_W'(1) : sf_reg[SIZE_W-1:0];
    assign s2c = ss_reg[FIELD_W-1] ? '0 : ss_reg[SIZE_W-1:0];

    assign mul_a = (op_reg == CMD_DIM) ? s1c : if_reg[SIZE_W-1:0];
    assign mul_b = (op_reg == CMD_DIM) ? s2c : ent_cols_reg;

    assign words     = (s2c == '0) ? PROD_W'(s1c) : prod_reg;
    assign eff_limit = (SUM_W'(limit_reg) < SUM_W'(HEAP_WORDS)) ? SUM_W'(limit_reg)
                                                                : SUM_W'(HEAP_WORDS);
    assign need_sum  = SUM_W'(fill_reg) + SUM_W'(words);

    assign off_sum  = (ent_cols_reg != '0) ? SUM_W'(prod_reg) + SUM_W'(is_reg[SIZE_W-1:0])
                                           : SUM_W'(if_reg[SIZE_W-1:0]);
    assign addr_sum = SUM_W'(ent_start_reg) + off_sum;
    assign ptr_inc  = ptr_reg + FILL_W'(1);

    always_comb begin
        flags            = '0;
        flags.op         = op_reg;
        flags.full       = full_reg;
        flags.oom        = need_sum > eff_limit;
        flags.bad_name   = !ent_dim_reg;
        flags.bad_sub    = if_reg[FIELD_W-1] || (if_reg[SIZE_W-1:0] >= ent_rows_reg) ||
                           ((ent_cols_reg != '0) &&
                            (is_reg[FIELD_W-1] || (is_reg[SIZE_W-1:0] >= ent_cols_reg)));
        flags.clear_last = (ptr_inc == end_reg);
        flags.out_free   = !m_valid_reg || m_tready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg     <= '0;
            count_reg   <= '0;
            fill_reg    <= '0;
            limit_reg   <= LIMIT_W'(LIMIT_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (cmd.take_entry && !hit_reg) begin
                count_reg        <= count_reg + COUNT_W'(1);
                dim_reg[idx_reg] <= 1'b0;
            end
            if (cmd.dim_fail) begin
                dim_reg[idx_reg] <= 1'b0;
            end
            if (cmd.dim_commit) begin
                dim_reg[idx_reg] <= 1'b1;
                fill_reg         <= need_sum[FILL_W-1:0];
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= cmd_t'(s_tuser);
            key_reg   <= s_tdata[KEY_W-1:0];
            sf_reg    <= s_tdata[79:64];
            ss_reg    <= s_tdata[95:80];
            if_reg    <= s_tdata[111:96];
            is_reg    <= s_tdata[127:112];
            wval_reg  <= s_tdata[191:128];
            value_reg <= '0;
        end
        if (cmd.lookup) begin
            hit_reg  <= hit;
            idx_reg  <= hit ? hit_idx : count_reg[ENTRY_W-1:0];
            full_reg <= !hit && (count_reg == COUNT_W'(MAX_ARRAYS));
        end
        if (cmd.take_entry && !hit_reg) begin
            keys_reg[idx_reg] <= key_reg;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.dim_commit) begin
            start_reg[idx_reg] <= fill_reg[HEAP_AW-1:0];
            rows_reg[idx_reg]  <= s1c;
            cols_reg[idx_reg]  <= s2c;
            ptr_reg            <= fill_reg;
            end_reg            <= need_sum[FILL_W-1:0];
        end
        if (cmd.clear_wr) begin
            ptr_reg <= ptr_inc;
        end
        if (cmd.fetch) begin
            ent_rows_reg  <= rows_reg[idx_reg];
            ent_cols_reg  <= cols_reg[idx_reg];
            ent_start_reg <= start_reg[idx_reg];
            ent_dim_reg   <= hit_reg && dim_reg[idx_reg];
        end
        if (cmd.addr_calc) begin
            addr_reg <= addr_sum[HEAP_AW-1:0];
        end
        if (cmd.rd_capture) begin
            value_reg <= ram_rdata;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.code;
        end
        if (cmd.load_out) begin
            m_data_reg <= {(M_DATA_W - WORD_W - STATUS_W)'(0), status_reg, value_reg};
        end
    end

    assign ram_we    = cmd.mem_wr || cmd.clear_wr;
    assign ram_waddr = cmd.clear_wr ? ptr_reg[HEAP_AW-1:0] : addr_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : wval_reg;

    das_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_ARRAYS))
        else $error("table count past capacity");

    a_take_bumps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_entry && !hit_reg |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("new entry did not advance count");

    a_clear_in_region: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> ptr_reg < end_reg)
        else $error("clear pointer left its region");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_wr && cmd.clear_wr))
        else $error("element write during clear");

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dim_commit |=> fill_reg > $past(fill_reg))
        else $error("allocation did not advance fill");

endmodule

`default_nettype wire

/* rtl/dimensioned_array_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// Dimension clears the heap words it allocates before it answers, one heap word cleared
// per cycle on the single write port. One item is in flight at a time; the next word is
// taken the cycle after its result is loaded into the output register.
// aresetn is synchronous, active low: it empties the name table, the heap fill and the
// output register and sets heap_limit to 4096; heap contents are not cleared.
module dimensioned_array_store
    import das_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // array_name[63:0], size_first[79:64], size_second[95:80], index_first[111:96],
    // index_second[127:112], write_value[191:128]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [CMD_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // read_value[63:0], status[66:64], zero pad
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LIMIT_W-1:0]  cfg_data
);

    das_cmd_t   cmd;
    das_flags_t flags;

    assign cfg_ready = 1'b1;

    das_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    das_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .flags     (flags),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
